[sv/sdes_pkg.sv]
`default_nettype none
package sdes_pkg;

	localparam int unsigned MinuteW = 11;
	localparam int unsigned DayW = 20;
	localparam int unsigned HalfHourW = 6;
	localparam int unsigned CountW = 7;
	localparam int unsigned CfgIndexW = 2;
	localparam int unsigned CfgDataW = 7;
	localparam int unsigned ProdW = 18;
	localparam int unsigned StepCntW = 5;
	localparam logic [StepCntW-1:0] LastStep = StepCntW'(ProdW - 1);

	localparam logic [CfgIndexW-1:0] REG_START = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_END = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_COUNT = 2'd2;

	localparam logic [HalfHourW-1:0] StartReset = 6'd16;
	localparam logic [HalfHourW-1:0] EndReset = 6'd38;
	localparam logic [CountW-1:0] CountReset = 7'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PREP,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic prep;
		logic div_step;
		logic finish;
	} ctrl_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} stat_t;

	function automatic logic [MinuteW-1:0] half_hours_to_min(input logic [HalfHourW-1:0] hh);
		logic [MinuteW-1:0] x;
		x = MinuteW'(hh);
		return (x << 5) - (x << 1);
	endfunction

endpackage
`default_nettype wire

[sv/sdes_ctrl.sv]
`default_nettype none
module sdes_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire sdes_pkg::stat_t stat,
	output sdes_pkg::ctrl_t     cmd
);

	sdes_pkg::state_t state_q;
	sdes_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdes_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sdes_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = sdes_pkg::ST_SETUP;
				end
			end
			sdes_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = sdes_pkg::ST_PREP;
			end
			sdes_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = sdes_pkg::ST_DIV;
			end
			sdes_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = sdes_pkg::ST_FINISH;
				end
			end
			sdes_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = sdes_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sdes_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[sv/sdes_dp.sv]
`default_nettype none
module sdes_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sdes_pkg::ctrl_t                     cmd,
	output sdes_pkg::stat_t                          stat,
	input  wire logic                                cfg_we,
	input  wire logic [sdes_pkg::CfgIndexW-1:0]      cfg_index,
	input  wire logic [sdes_pkg::CfgDataW-1:0]       cfg_data,
	input  wire logic [sdes_pkg::MinuteW-1:0]        minute_of_day,
	input  wire logic [sdes_pkg::DayW-1:0]           day_number,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     fire_now
);

	logic [sdes_pkg::HalfHourW-1:0] start_q;
	logic [sdes_pkg::HalfHourW-1:0] end_q;
	logic [sdes_pkg::CountW-1:0]    count_q;
	logic [sdes_pkg::MinuteW-1:0]   last_min_q;
	logic [sdes_pkg::DayW-1:0]      last_day_q;
	logic [sdes_pkg::MinuteW-1:0]   cur_q;
	logic [sdes_pkg::DayW-1:0]      day_q;
	logic [sdes_pkg::MinuteW-1:0]   m_q;
	logic [sdes_pkg::MinuteW-1:0]   e_q;
	logic [sdes_pkg::MinuteW-1:0]   d_q;
	logic [sdes_pkg::ProdW-1:0]     a_q;
	logic [sdes_pkg::MinuteW-1:0]   rem_q;
	logic [sdes_pkg::StepCntW-1:0]  step_q;
	logic                           spec_q;
	logic                           spec_val_q;
	logic                           out_valid_q;
	logic                           fire_q;

	logic [sdes_pkg::CountW-1:0]    nm1;
	logic [sdes_pkg::MinuteW-1:0]   d_d;
	logic                           out_win;
	logic                           n_zero;
	logic                           n_single;
	logic [sdes_pkg::MinuteW:0]     trial;
	logic [sdes_pkg::MinuteW:0]     d_ext;
	logic [sdes_pkg::MinuteW-1:0]   back;
	logic [sdes_pkg::MinuteW-1:0]   slot_gap;
	logic                           near;
	logic                           repeat_hit;
	logic                           fire_d;

	assign nm1 = count_q - sdes_pkg::CountW'(1);
	assign d_d = e_q - m_q;
	assign out_win = (cur_q < m_q) || (cur_q > e_q);
	assign n_zero = (count_q == '0);
	assign n_single = (count_q == sdes_pkg::CountW'(1)) || (d_d == '0);
	assign trial = {rem_q, a_q[sdes_pkg::ProdW-1]};
	assign d_ext = {1'b0, d_q};
	assign back = d_q - rem_q;
	assign slot_gap = (back < rem_q) ? back : rem_q;
	assign near = spec_q ? spec_val_q
		: ({1'b0, slot_gap} << 1) <= (sdes_pkg::MinuteW+1)'(nm1);
	assign repeat_hit = (last_min_q == cur_q) && (last_day_q == day_q);
	assign fire_d = near && !repeat_hit;

	assign stat.div_last = (step_q == sdes_pkg::LastStep);
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign fire_now = fire_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= sdes_pkg::StartReset;
			end_q <= sdes_pkg::EndReset;
			count_q <= sdes_pkg::CountReset;
		end else if (cfg_we) begin
			priority case (cfg_index)
				sdes_pkg::REG_START: start_q <= cfg_data[sdes_pkg::HalfHourW-1:0];
				sdes_pkg::REG_END:   end_q <= cfg_data[sdes_pkg::HalfHourW-1:0];
				sdes_pkg::REG_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_min_q <= '1;
			last_day_q <= '1;
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
			if (fire_d) begin
				last_min_q <= cur_q;
				last_day_q <= day_q;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= minute_of_day;
			day_q <= day_number;
		end
		if (cmd.setup) begin
			m_q <= sdes_pkg::half_hours_to_min(start_q);
			e_q <= sdes_pkg::half_hours_to_min(end_q);
		end
		if (cmd.prep) begin
			d_q <= d_d;
			a_q <= sdes_pkg::ProdW'(cur_q - m_q) * sdes_pkg::ProdW'(nm1);
			rem_q <= '0;
			step_q <= '0;
			spec_q <= n_zero || out_win || n_single;
			spec_val_q <= !n_zero && !out_win && (cur_q == m_q);
		end
		if (cmd.div_step) begin
			if (trial >= d_ext) begin
				rem_q <= sdes_pkg::MinuteW'(trial - d_ext);
			end else begin
				rem_q <= trial[sdes_pkg::MinuteW-1:0];
			end
			a_q <= a_q << 1;
			step_q <= step_q + sdes_pkg::StepCntW'(1);
		end
		if (cmd.finish) begin
			fire_q <= fire_d;
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && (d_q != '0) && (rem_q < d_q) |=> (rem_q < d_q))
		else $error("remainder reached divisor");

	a_fire_latches_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && fire_d |=> (last_min_q == $past(cur_q)) && (last_day_q == $past(day_q)))
		else $error("firing not recorded");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && (fire_q == $past(fire_d)))
		else $error("result word not presented");

	a_repeat_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && repeat_hit |=> !fire_q && $stable(last_min_q) && $stable(last_day_q))
		else $error("repeat firing");

endmodule
`default_nettype wire

[sv/spaced_daily_event_scheduler_unit.sv]
// Steps from input word accept to output word valid: setup, product,
// 18 restoring remainder steps, finish (finish waits while the output is held).
// A new input word is taken only when idle, once the bit-serial remainder unit
// and finish are done; it may be taken while the previous output word waits.
// Reset: async active low; registers return to 16/38/2, last firing to all ones.
`default_nettype none
module spaced_daily_event_scheduler_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sdes_pkg::CfgIndexW-1:0]    cfg_index,
	input  wire logic [sdes_pkg::CfgDataW-1:0]     cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [sdes_pkg::MinuteW-1:0]      minute_of_day,
	input  wire logic [sdes_pkg::DayW-1:0]         day_number,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   fire_now
);

	sdes_pkg::ctrl_t cmd;
	sdes_pkg::stat_t stat;

	sdes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sdes_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.minute_of_day (minute_of_day),
		.day_number    (day_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fire_now      (fire_now)
	);

endmodule
`default_nettype wire

[tb/sv/spaced_daily_event_scheduler_unit_tb.sv]
`default_nettype none
module spaced_daily_event_scheduler_unit_tb;
	import sdes_pkg::*;

	localparam logic [CfgIndexW-1:0] REG_NONE = 2'd3;
	localparam int MinPerHalfHour = 30;
	localparam int MaxIdle = 9;
	localparam int RandPhases = 22;
	localparam int ItemsPerPhase = 50;

	typedef struct packed {
		logic [MinuteW-1:0] minute;
		logic [DayW-1:0] day;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MinuteW-1:0] minute_of_day = '0;
	logic [DayW-1:0] day_number = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic fire_now;

	sample_t sample_q[$];
	logic fire_exp_q[$];

	logic [HalfHourW-1:0] start_hh = StartReset;
	logic [HalfHourW-1:0] end_hh = EndReset;
	logic [CountW-1:0] ev_count = CountReset;
	logic [MinuteW-1:0] last_min = '1;
	logic [DayW-1:0] last_day = '1;

	int err_cnt = 0;
	int in_acc_cnt = 0;
	int in_seen_cnt = 0;
	int out_acc_cnt = 0;
	int out_seen_cnt = 0;
	int in_gap_max = MaxIdle;
	int out_gap_max = MaxIdle;
	int in_gap = 0;
	int out_stall = 0;
	logic in_busy = 1'b0;
	logic out_drawn = 1'b0;

	spaced_daily_event_scheduler_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.minute_of_day(minute_of_day),
		.day_number(day_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fire_now(fire_now)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic near_slot(input logic [MinuteW-1:0] cur);
		logic [MinuteW-1:0] m;
		logic [MinuteW-1:0] e;
		logic [MinuteW-1:0] d;
		logic [MinuteW-1:0] r;
		logic [MinuteW-1:0] slot_gap;
		logic [CountW-1:0] nm1;
		logic [ProdW-1:0] prod;
		m = start_hh * MinuteW'(MinPerHalfHour);
		e = end_hh * MinuteW'(MinPerHalfHour);
		if (ev_count == '0)
			return 1'b0;
		if (cur < m || cur > e)
			return 1'b0;
		d = e - m;
		if (ev_count == CountW'(1) || d == '0)
			return cur == m;
		nm1 = ev_count - CountW'(1);
		prod = ProdW'(cur - m) * ProdW'(nm1);
		r = MinuteW'(prod % ProdW'(d));
		slot_gap = (d - r < r) ? d - r : r;
		return (12'(slot_gap) << 1) <= 12'(nm1);
	endfunction

	function automatic logic predict_fire(input logic [MinuteW-1:0] cur,
			input logic [DayW-1:0] day);
		if (near_slot(cur) && (last_min != cur || last_day != day)) begin
			last_min = cur;
			last_day = day;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		logic want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				out_acc_cnt++;
				if (fire_exp_q.size() == 0) begin
					$error("fire_now: expected none, actual %0b", fire_now);
					err_cnt++;
				end else begin
					want = fire_exp_q.pop_front();
					if (fire_now !== want) begin
						$error("fire_now: expected %0b, actual %0b", want, fire_now);
						err_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				in_acc_cnt++;
				fire_exp_q.push_back(predict_fire(minute_of_day, day_number));
			end
		end
	end

	always @(negedge clk) begin
		sample_t s;
		if (arst_n) begin
			if (in_busy && in_acc_cnt != in_seen_cnt) begin
				in_seen_cnt = in_acc_cnt;
				in_busy = 1'b0;
				in_gap = $urandom_range(0, in_gap_max);
			end
			if (!in_busy) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (sample_q.size() != 0) begin
					s = sample_q.pop_front();
					minute_of_day <= s.minute;
					day_number <= s.day;
					in_busy = 1'b1;
				end
			end
			in_valid <= in_busy;
		end
	end

	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (out_acc_cnt != out_seen_cnt) begin
				out_seen_cnt = out_acc_cnt;
				out_drawn = 1'b0;
			end
			if (out_valid && !out_drawn) begin
				out_drawn = 1'b1;
				out_stall = $urandom_range(0, out_gap_max);
			end
			if (out_drawn) begin
				if (out_stall > 0) begin
					out_stall--;
					rdy = 1'b0;
				end else begin
					rdy = 1'b1;
				end
			end else begin
				rdy = (out_gap_max == 0) || ($urandom_range(0, 1) == 1);
			end
			out_ready <= rdy;
		end
	end

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START: start_hh = val[HalfHourW-1:0];
			REG_END: end_hh = val[HalfHourW-1:0];
			REG_COUNT: ev_count = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input int s, input int e, input int c);
		write_reg(REG_START, CfgDataW'(s));
		write_reg(REG_END, CfgDataW'(e));
		write_reg(REG_COUNT, CfgDataW'(c));
	endtask

	task automatic put(input int cur, input int day);
		sample_q.push_back('{MinuteW'(cur), DayW'(day)});
	endtask

	task automatic wait_idle();
		while (sample_q.size() != 0 || in_busy || in_valid || fire_exp_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic int pick_half_hour();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 48;
			2: return 63;
			3: return $urandom_range(0, 127);
			default: return $urandom_range(0, 48);
		endcase
	endfunction

	function automatic int pick_count();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 64;
			3: return 127;
			4: return $urandom_range(0, 64);
			default: return $urandom_range(2, 10);
		endcase
	endfunction

	function automatic sample_t make_sample(input sample_t prev);
		int m;
		int e;
		int n;
		int k;
		int cur;
		sample_t s;
		m = start_hh * MinPerHalfHour;
		e = end_hh * MinPerHalfHour;
		n = ev_count;
		case ($urandom_range(0, 9))
			6: return prev;
			7: begin
				case ($urandom_range(0, 3))
					0: cur = m;
					1: cur = e;
					2: cur = m - 1;
					default: cur = e + 1;
				endcase
			end
			8, 9: cur = $urandom_range(0, 2047);
			default: begin
				if (n >= 2 && e > m) begin
					k = $urandom_range(0, n - 1);
					cur = m + (k * (e - m) + (n - 1) / 2) / (n - 1);
				end else begin
					cur = m;
				end
				cur = cur + int'($urandom_range(0, 2)) - 1;
			end
		endcase
		s.minute = MinuteW'(cur);
		if ($urandom_range(0, 4) == 0)
			s.day = DayW'($urandom());
		else
			s.day = DayW'($urandom_range(0, 3));
		return s;
	endfunction

	initial begin
		sample_t prev;
		int s;
		int e;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		put(480, 0);
		put(480, 0);
		put(1140, 0);
		put(479, 0);
		put(1141, 0);
		put(481, 5);
		put(2047, 20'hFFFFF);
		put(810, 20'hFFFFF);
		put(0, 0);
		wait_idle();

		set_config(16, 38, 0);
		put(480, 7);
		wait_idle();

		set_config(10, 20, 1);
		put(300, 0);
		put(301, 0);
		wait_idle();

		set_config(20, 20, 5);
		put(600, 0);
		put(601, 0);
		wait_idle();

		set_config(30, 10, 3);
		put(900, 0);
		put(300, 0);
		wait_idle();

		set_config(0, 48, 64);
		put(0, 0);
		put(1440, 0);
		put(1439, 1);
		wait_idle();

		// slot spacing under one minute: neighboring slots tie
		set_config(16, 17, 64);
		put(495, 0);
		put(510, 0);
		wait_idle();

		set_config(63, 63, 127);
		write_reg(REG_NONE, 7'h7F);
		write_reg(REG_NONE, 7'h00);
		put(1890, 9);
		put(2047, 9);
		wait_idle();

		prev = '{MinuteW'(0), DayW'(0)};
		for (int p = 0; p < RandPhases; p++) begin
			s = pick_half_hour();
			if (s <= 48 && $urandom_range(0, 9) < 7)
				e = s + $urandom_range(0, 48 - s);
			else
				e = pick_half_hour();
			set_config(s, e, pick_count());
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_NONE, CfgDataW'($urandom()));
			in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxIdle;
			out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxIdle;
			for (int i = 0; i < ItemsPerPhase; i++) begin
				prev = make_sample(prev);
				sample_q.push_back(prev);
			end
			wait_idle();
		end

		repeat (30) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
sv/sdes_pkg.sv
sv/sdes_ctrl.sv
sv/sdes_dp.sv
sv/spaced_daily_event_scheduler_unit.sv
tb/sv/spaced_daily_event_scheduler_unit_tb.sv
